/* hdl/bfra_pkg.sv */
// shared types and codes of the best-fit range allocator
package bfra_pkg;

    // widest range word and widest table index over the parameter ranges
    localparam int OFS_MAX_W = 64;
    localparam int IDX_MAX_W = 10;

    typedef logic [OFS_MAX_W-1:0] t_ofs;
    typedef logic [IDX_MAX_W-1:0] t_idx;

    // action codes
    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_FREE    = 2'd1;
    localparam logic [1:0] ACT_DEFER   = 2'd2;
    localparam logic [1:0] ACT_RELEASE = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_TFULL  = 2'd2;
    localparam logic [1:0] ST_QFULL  = 2'd3;

    // one candidate entry found during a pass
    typedef struct packed {
        logic found;
        t_idx idx;
        t_ofs start;
        t_ofs len;
    } t_cand;

    // token that walks the cell row
    typedef struct packed {
        t_ofs  q_ofs;
        t_ofs  q_len;
        t_cand best;
        t_cand prev;
        t_cand next;
        logic  emp_found;
        t_idx  emp_idx;
    } t_tok;

    // broadcast write to one cell
    typedef struct packed {
        logic en;
        t_idx idx;
        t_ofs start;
        t_ofs len;
        logic valid;
    } t_wr;

    // table reload to one free block
    typedef struct packed {
        logic en;
        t_ofs len;
    } t_init;

endpackage

/* hdl/best_fit_range_allocator.sv */
// best-fit range allocator: sequencer, deferred queue and cell row
// allocate and free: a token pass over the cell row, the table update, then the result beat;
// a two-sided merge adds a retire step; deferred free and zero-size actions go straight to the
// result beat; release frees the due queue entries, a nonzero one by a pass; one action at a time;
// the next beat is taken the cycle after the result beat has left
// reset: table holds one free block [0, 1048576), deferred queue empty
module best_fit_range_allocator #(
    parameter int FREE_BLOCKS = 64,
    parameter int STALE_DEPTH = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_offset,
    input  logic [31:0] i_size,
    input  logic [63:0] i_fence,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_alloc_offset,
    output logic [31:0] o_free_total,
    output logic [4:0]  o_released_count,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data
);
    localparam int DATA_W = OFFSET_BITS;
    localparam int SW     = DATA_W + 1;
    localparam int IN_W   = (OFFSET_BITS < 32) ? OFFSET_BITS : 32;
    localparam int SIDX_W = (STALE_DEPTH > 1) ? $clog2(STALE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STALE_DEPTH + 1);
    localparam int TW     = ((SIDX_W > CNT_W) ? SIDX_W : CNT_W) + 1;
    localparam int CW     = $clog2(FREE_BLOCKS + 1);
    localparam logic [31:0]       RESET_SIZE = 32'd1048576;
    localparam logic [DATA_W-1:0] ALL1       = '1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_UPD    = 3'd2;
    localparam logic [2:0] S_KILL   = 3'd3;
    localparam logic [2:0] S_RLS_RD = 3'd4;
    localparam logic [2:0] S_RLS_CK = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0]        r_state;
    logic [1:0]        r_action;
    logic [DATA_W-1:0] r_ofs;
    logic [DATA_W-1:0] r_len;
    logic [63:0]       r_fence;
    logic [1:0]        r_status;
    logic [31:0]       r_grant;
    logic [CNT_W-1:0]  r_released;
    logic [DATA_W-1:0] r_free;
    logic [SIDX_W-1:0] r_head;
    logic [CNT_W-1:0]  r_count;
    logic [CW-1:0]     r_scan;
    bfra_pkg::t_idx    r_kill;

    logic [DATA_W-1:0] m_start [STALE_DEPTH];
    logic [DATA_W-1:0] m_len   [STALE_DEPTH];
    logic [63:0]       m_fence [STALE_DEPTH];
    logic [DATA_W-1:0] r_rd_start;
    logic [DATA_W-1:0] r_rd_len;
    logic [63:0]       r_rd_fence;

    bfra_pkg::t_init w_init;
    bfra_pkg::t_wr   w_wr;
    bfra_pkg::t_tok  w_tok_in;
    bfra_pkg::t_tok  w_tail;
    logic [DATA_W-1:0] w_init_len;
    logic [DATA_W-1:0] w_in_ofs;
    logic [DATA_W-1:0] w_in_len;
    logic              w_in_beat;
    logic              w_out_beat;

    logic [SW-1:0]     w_bstart, w_pstart, w_nstart;
    logic [DATA_W-1:0] w_blen, w_plen, w_nlen;
    logic [SW:0]       w_prev_end;
    logic [SW-1:0]     w_q_end;
    logic              w_jp, w_jn;
    logic [DATA_W:0]   w_m1, w_m2, w_m3, w_mf;
    logic [DATA_W-1:0] w_s1, w_s2, w_s3, w_sf;
    logic              w_free_ok;
    logic [TW-1:0]     w_tail_sum;
    logic [TW-1:0]     w_tail_wrap;
    logic [SIDX_W-1:0] w_qtail;
    logic [SIDX_W-1:0] w_head_inc;
    logic              w_qwr;

    assign w_in_beat  = i_in_valid && o_in_ready;
    assign w_out_beat = o_out_valid && i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    // field masking to the address width
    assign w_in_ofs   = DATA_W'(i_offset[IN_W-1:0]);
    assign w_in_len   = DATA_W'(i_size[IN_W-1:0]);
    assign w_init_len = !i_rst_n ? DATA_W'(RESET_SIZE[IN_W-1:0]) :
                                   DATA_W'(i_cfg_data[IN_W-1:0]);
    assign w_init.en  = !i_rst_n || i_cfg_we;
    assign w_init.len = bfra_pkg::t_ofs'(w_init_len);

    // query token entering the first cell
    always_comb begin
        w_tok_in       = '0;
        w_tok_in.q_ofs = bfra_pkg::t_ofs'(r_ofs);
        w_tok_in.q_len = bfra_pkg::t_ofs'(r_len);
    end

    bfra_chain #(
        .FREE_BLOCKS (FREE_BLOCKS),
        .DATA_W      (DATA_W)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_init  (w_init),
        .i_wr    (w_wr),
        .i_tok   (w_tok_in),
        .o_tok   (w_tail)
    );

    // pass result and merge arithmetic
    always_comb begin
        w_bstart   = w_tail.best.start[SW-1:0];
        w_blen     = w_tail.best.len[DATA_W-1:0];
        w_pstart   = w_tail.prev.start[SW-1:0];
        w_plen     = w_tail.prev.len[DATA_W-1:0];
        w_nstart   = w_tail.next.start[SW-1:0];
        w_nlen     = w_tail.next.len[DATA_W-1:0];
        w_prev_end = {1'b0, w_pstart} + (SW+1)'(w_plen);
        w_q_end    = SW'(r_ofs) + SW'(r_len);
        w_jp = w_tail.prev.found && (w_prev_end == (SW+1)'(r_ofs));
        w_jn = w_tail.next.found && (w_q_end == w_nstart);
        w_m1 = {1'b0, w_plen} + {1'b0, r_len};
        w_s1 = w_m1[DATA_W] ? ALL1 : w_m1[DATA_W-1:0];
        w_m2 = {1'b0, w_s1} + {1'b0, w_nlen};
        w_s2 = w_m2[DATA_W] ? ALL1 : w_m2[DATA_W-1:0];
        w_m3 = {1'b0, r_len} + {1'b0, w_nlen};
        w_s3 = w_m3[DATA_W] ? ALL1 : w_m3[DATA_W-1:0];
        w_mf = {1'b0, r_free} + {1'b0, r_len};
        w_sf = w_mf[DATA_W] ? ALL1 : w_mf[DATA_W-1:0];
        w_free_ok = w_jp || w_jn || w_tail.emp_found;
    end

    // broadcast write into the cell row
    always_comb begin
        w_wr = '0;
        if (r_state == S_UPD) begin
            if (r_action == bfra_pkg::ACT_ALLOC) begin
                w_wr.en    = w_tail.best.found;
                w_wr.idx   = w_tail.best.idx;
                w_wr.start = bfra_pkg::t_ofs'(w_bstart + SW'(r_len));
                w_wr.len   = bfra_pkg::t_ofs'(w_blen - r_len);
                w_wr.valid = (w_blen != r_len);
            end else if (w_jp) begin
                w_wr.en    = 1'b1;
                w_wr.idx   = w_tail.prev.idx;
                w_wr.start = bfra_pkg::t_ofs'(w_pstart);
                w_wr.len   = bfra_pkg::t_ofs'(w_jn ? w_s2 : w_s1);
                w_wr.valid = 1'b1;
            end else if (w_jn) begin
                w_wr.en    = 1'b1;
                w_wr.idx   = w_tail.next.idx;
                w_wr.start = bfra_pkg::t_ofs'(r_ofs);
                w_wr.len   = bfra_pkg::t_ofs'(w_s3);
                w_wr.valid = 1'b1;
            end else begin
                w_wr.en    = w_tail.emp_found;
                w_wr.idx   = w_tail.emp_idx;
                w_wr.start = bfra_pkg::t_ofs'(r_ofs);
                w_wr.len   = bfra_pkg::t_ofs'(r_len);
                w_wr.valid = 1'b1;
            end
        end else if (r_state == S_KILL) begin
            w_wr.en  = 1'b1;
            w_wr.idx = r_kill;
        end
    end

    // deferred queue pointers
    always_comb begin
        w_tail_sum  = TW'(r_head) + TW'(r_count);
        w_tail_wrap = (w_tail_sum >= TW'(STALE_DEPTH)) ? w_tail_sum - TW'(STALE_DEPTH)
                                                       : w_tail_sum;
        w_qtail     = w_tail_wrap[SIDX_W-1:0];
        w_head_inc  = (r_head == SIDX_W'(STALE_DEPTH - 1)) ? '0 : r_head + 1'b1;
        w_qwr       = w_in_beat && (i_action == bfra_pkg::ACT_DEFER) &&
                      (r_count < CNT_W'(STALE_DEPTH));
    end

    // deferred queue storage, read registered at the head
    always_ff @(posedge i_clk) begin
        if (w_qwr) begin
            m_start[w_qtail] <= w_in_ofs;
            m_len[w_qtail]   <= w_in_len;
            m_fence[w_qtail] <= i_fence;
        end
        r_rd_start <= m_start[r_head];
        r_rd_len   <= m_len[r_head];
        r_rd_fence <= m_fence[r_head];
    end

    // action sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_free     <= w_init_len;
            r_head     <= '0;
            r_count    <= '0;
            r_scan     <= '0;
            r_released <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_we) begin
                        r_free  <= w_init_len;
                        r_head  <= '0;
                        r_count <= '0;
                    end
                    if (w_in_beat) begin
                        r_action   <= i_action;
                        r_ofs      <= w_in_ofs;
                        r_len      <= w_in_len;
                        r_fence    <= i_fence;
                        r_status   <= bfra_pkg::ST_OK;
                        r_grant    <= '0;
                        r_released <= '0;
                        r_scan     <= '0;
                        case (i_action)
                            bfra_pkg::ACT_ALLOC: begin
                                if (w_in_len == '0) begin
                                    r_status <= bfra_pkg::ST_NOFIT;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            bfra_pkg::ACT_FREE: begin
                                r_state <= (w_in_len == '0) ? S_OUT : S_SCAN;
                            end
                            bfra_pkg::ACT_DEFER: begin
                                if (w_qwr) begin
                                    r_count <= r_count + 1'b1;
                                end else begin
                                    r_status <= bfra_pkg::ST_QFULL;
                                end
                                r_state <= S_OUT;
                            end
                            default: begin
                                r_state <= S_RLS_RD;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_scan <= r_scan + 1'b1;
                    if (r_scan == CW'(FREE_BLOCKS)) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (r_action == bfra_pkg::ACT_ALLOC) begin
                        if (w_tail.best.found) begin
                            r_grant <= 32'(w_bstart);
                            r_free  <= (r_free >= r_len) ? r_free - r_len : '0;
                        end else begin
                            r_status <= bfra_pkg::ST_NOFIT;
                        end
                        r_state <= S_OUT;
                    end else if (!w_free_ok) begin
                        r_status <= bfra_pkg::ST_TFULL;
                        r_state  <= S_OUT;
                    end else begin
                        r_free <= w_sf;
                        r_kill <= w_tail.next.idx;
                        if (r_action == bfra_pkg::ACT_RELEASE) begin
                            r_head     <= w_head_inc;
                            r_count    <= r_count - 1'b1;
                            r_released <= r_released + 1'b1;
                        end
                        if (w_jp && w_jn) begin
                            r_state <= S_KILL;
                        end else begin
                            r_state <= (r_action == bfra_pkg::ACT_FREE) ? S_OUT : S_RLS_RD;
                        end
                    end
                end
                S_KILL: begin
                    r_state <= (r_action == bfra_pkg::ACT_FREE) ? S_OUT : S_RLS_RD;
                end
                S_RLS_RD: begin
                    r_state <= (r_count == '0) ? S_OUT : S_RLS_CK;
                end
                S_RLS_CK: begin
                    if (r_rd_fence <= r_fence) begin
                        if (r_rd_len == '0) begin
                            r_head     <= w_head_inc;
                            r_count    <= r_count - 1'b1;
                            r_released <= r_released + 1'b1;
                            r_state    <= S_RLS_RD;
                        end else begin
                            r_ofs   <= r_rd_start;
                            r_len   <= r_rd_len;
                            r_scan  <= '0;
                            r_state <= S_SCAN;
                        end
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_beat) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result beat
    assign o_status         = r_status;
    assign o_alloc_offset   = r_grant;
    assign o_free_total     = 32'(r_free);
    assign o_released_count = 5'(r_released);

    // queue never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STALE_DEPTH))
        else $error("deferred queue count above depth");

    // a pass never runs past the last cell
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_scan <= CW'(FREE_BLOCKS)))
        else $error("scan counter overrun");

    // queue-full status only answers a deferred free
    a_qfull_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == bfra_pkg::ST_QFULL) |->
        (r_action == bfra_pkg::ACT_DEFER))
        else $error("queue full reported for wrong action");

    // a merge on both sides retires the upper neighbor next cycle
    a_kill_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_KILL) |-> ($past(r_state) == S_UPD))
        else $error("entry retire without a preceding update");

    // an accepted action always leaves idle
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat |=> (r_state != S_IDLE))
        else $error("accepted beat dropped");

endmodule

/* hdl/bfra_cell.sv */
// one free-table entry with its stage of the search token
module bfra_cell #(
    parameter int CELL_IDX = 0,
    parameter int DATA_W   = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bfra_pkg::t_init i_init,
    input  bfra_pkg::t_wr   i_wr,
    input  bfra_pkg::t_tok  i_tok,
    output bfra_pkg::t_tok  o_tok
);
    localparam int SW = DATA_W + 1;

    logic              r_valid;
    logic [SW-1:0]     r_start;
    logic [DATA_W-1:0] r_len;
    bfra_pkg::t_tok    r_tok;
    bfra_pkg::t_tok    n_tok;
    bfra_pkg::t_cand   w_me;
    logic              w_sel;

    assign w_sel = i_wr.en && (i_wr.idx == bfra_pkg::t_idx'(CELL_IDX));

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= (CELL_IDX == 0) && (i_init.len != '0);
        end else if (i_init.en) begin
            r_valid <= (CELL_IDX == 0) && (i_init.len != '0);
        end else if (w_sel) begin
            r_valid <= i_wr.valid;
        end
    end

    // entry range
    always_ff @(posedge i_clk) begin
        if (i_init.en) begin
            r_start <= '0;
            r_len   <= i_init.len[DATA_W-1:0];
        end else if (w_sel) begin
            r_start <= i_wr.start[SW-1:0];
            r_len   <= i_wr.len[DATA_W-1:0];
        end
    end

    // fold this entry into the token
    always_comb begin
        w_me.found = 1'b1;
        w_me.idx   = bfra_pkg::t_idx'(CELL_IDX);
        w_me.start = bfra_pkg::t_ofs'(r_start);
        w_me.len   = bfra_pkg::t_ofs'(r_len);
        n_tok = i_tok;
        if (!r_valid) begin
            if (!i_tok.emp_found) begin
                n_tok.emp_found = 1'b1;
                n_tok.emp_idx   = w_me.idx;
            end
        end else begin
            if (w_me.len >= i_tok.q_len &&
                (!i_tok.best.found || w_me.len < i_tok.best.len ||
                 (w_me.len == i_tok.best.len && w_me.start < i_tok.best.start))) begin
                n_tok.best = w_me;
            end
            if (w_me.start <= i_tok.q_ofs) begin
                if (!i_tok.prev.found || w_me.start > i_tok.prev.start) begin
                    n_tok.prev = w_me;
                end
            end else if (!i_tok.next.found || w_me.start < i_tok.next.start) begin
                n_tok.next = w_me;
            end
        end
    end

    // hand to the neighbor
    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
    end

    assign o_tok = r_tok;

endmodule

/* hdl/bfra_chain.sv */
// row of table cells that the search token passes through
module bfra_chain #(
    parameter int FREE_BLOCKS = 64,
    parameter int DATA_W      = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bfra_pkg::t_init i_init,
    input  bfra_pkg::t_wr   i_wr,
    input  bfra_pkg::t_tok  i_tok,
    output bfra_pkg::t_tok  o_tok
);
    bfra_pkg::t_tok w_tok [FREE_BLOCKS+1];

    assign w_tok[0] = i_tok;

    // one cell per entry, token moves one cell a cycle
    for (genvar g = 0; g < FREE_BLOCKS; g++) begin : g_cell
        bfra_cell #(
            .CELL_IDX (g),
            .DATA_W   (DATA_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_init  (i_init),
            .i_wr    (i_wr),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    assign o_tok = w_tok[FREE_BLOCKS];

endmodule

/* tb/sv/tb_best_fit_range_allocator.sv */
// testbench for the best-fit range allocator: scoreboard against a behavioral table model
`timescale 1ns / 1ps

module tb_best_fit_range_allocator;

    localparam int NBLK = 64;
    localparam int NQ = 16;
    localparam longint unsigned OMASK = 64'hFFFF_FFFF;
    localparam int WATCHDOG = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_action = bfra_pkg::ACT_ALLOC;
    logic [31:0] i_offset = '0;
    logic [31:0] i_size = '0;
    logic [63:0] i_fence = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_alloc_offset;
    logic [31:0] o_free_total;
    logic [4:0]  o_released_count;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_data = '0;

    best_fit_range_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_action(i_action), .i_offset(i_offset), .i_size(i_size), .i_fence(i_fence),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_status(o_status), .o_alloc_offset(o_alloc_offset),
        .o_free_total(o_free_total), .o_released_count(o_released_count),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] grant;
        logic [31:0] free_total;
        logic [4:0]  released;
    } t_answer;

    // model state of the free table and the deferred queue
    longint unsigned blk_start [NBLK];
    longint unsigned blk_len [NBLK];
    bit              blk_vld [NBLK];
    longint unsigned units_free;
    longint unsigned q_start [NQ];
    longint unsigned q_len [NQ];
    longint unsigned q_fence [NQ];
    int              q_head;
    int              q_cnt;

    t_answer answers_due [$];
    int      n_errors = 0;
    int      idle_pct = 35;
    bit      hold_off = 1'b0;
    int      quiet_cycles = 0;

    function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s > OMASK) ? OMASK : s;
    endfunction

    function automatic void table_load(longint unsigned total);
        foreach (blk_vld[i]) blk_vld[i] = 1'b0;
        if (total != 0) begin
            blk_start[0] = 0;
            blk_len[0] = total;
            blk_vld[0] = 1'b1;
        end
        units_free = total;
        q_head = 0;
        q_cnt = 0;
    endfunction

    // return a range to the table with merging; 0 when the table is full
    function automatic bit table_return(longint unsigned ofs, longint unsigned len);
        int prv, nxt, emp;
        bit jp, jn;
        prv = -1; nxt = -1; emp = -1;
        if (len == 0) return 1'b1;
        for (int i = 0; i < NBLK; i++) begin
            if (!blk_vld[i]) begin
                if (emp < 0) emp = i;
            end else if (blk_start[i] <= ofs) begin
                if (prv < 0 || blk_start[i] > blk_start[prv]) prv = i;
            end else begin
                if (nxt < 0 || blk_start[i] < blk_start[nxt]) nxt = i;
            end
        end
        jp = prv >= 0 && blk_start[prv] + blk_len[prv] == ofs;
        jn = nxt >= 0 && ofs + len == blk_start[nxt];
        if (jp && jn) begin
            blk_len[prv] = sat_sum(sat_sum(blk_len[prv], len), blk_len[nxt]);
            blk_vld[nxt] = 1'b0;
        end else if (jp) begin
            blk_len[prv] = sat_sum(blk_len[prv], len);
        end else if (jn) begin
            blk_start[nxt] = ofs;
            blk_len[nxt] = sat_sum(len, blk_len[nxt]);
        end else begin
            if (emp < 0) return 1'b0;
            blk_start[emp] = ofs;
            blk_len[emp] = len;
            blk_vld[emp] = 1'b1;
        end
        units_free = sat_sum(units_free, len);
        return 1'b1;
    endfunction

    function automatic t_answer predict_action(logic [1:0] act, logic [31:0] ofs,
                                               logic [31:0] len, logic [63:0] fence);
        t_answer a;
        int best;
        int h;
        a = '0;
        best = -1;
        case (act)
            bfra_pkg::ACT_ALLOC: begin
                if (len != 0)
                    for (int i = 0; i < NBLK; i++) begin
                        if (!blk_vld[i] || blk_len[i] < len) continue;
                        if (best < 0 || blk_len[i] < blk_len[best] ||
                            (blk_len[i] == blk_len[best] && blk_start[i] < blk_start[best]))
                            best = i;
                    end
                if (best < 0) begin
                    a.status = bfra_pkg::ST_NOFIT;
                end else begin
                    a.grant = blk_start[best][31:0];
                    if (blk_len[best] == len) begin
                        blk_vld[best] = 1'b0;
                    end else begin
                        blk_start[best] += 64'(len);
                        blk_len[best] -= 64'(len);
                    end
                    units_free = (units_free >= len) ? units_free - 64'(len) : 64'd0;
                end
            end
            bfra_pkg::ACT_FREE: begin
                if (!table_return(64'(ofs), 64'(len))) a.status = bfra_pkg::ST_TFULL;
            end
            bfra_pkg::ACT_DEFER: begin
                if (q_cnt >= NQ) begin
                    a.status = bfra_pkg::ST_QFULL;
                end else begin
                    h = (q_head + q_cnt) % NQ;
                    q_start[h] = 64'(ofs);
                    q_len[h] = 64'(len);
                    q_fence[h] = fence;
                    q_cnt++;
                end
            end
            default: begin
                while (q_cnt > 0 && q_fence[q_head] <= fence) begin
                    if (!table_return(q_start[q_head], q_len[q_head])) begin
                        a.status = bfra_pkg::ST_TFULL;
                        break;
                    end
                    q_head = (q_head + 1) % NQ;
                    q_cnt--;
                    a.released++;
                end
            end
        endcase
        a.free_total = units_free[31:0];
        return a;
    endfunction

    // send one beat and queue its expected answer on acceptance
    task automatic send_action(logic [1:0] act, logic [31:0] ofs, logic [31:0] len,
                               logic [63:0] fence);
        @(negedge i_clk);
        while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_action <= act;
        i_offset <= ofs;
        i_size <= len;
        i_fence <= fence;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        answers_due.push_back(predict_action(act, ofs, len, fence));
    endtask

    task automatic drain_wait();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (answers_due.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic write_total(logic [31:0] total);
        drain_wait();
        i_cfg_data <= total;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        table_load(64'(total));
    endtask

    // receiver with random stalls and an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_off) i_out_ready <= 1'b0;
        else i_out_ready <= ($urandom_range(99, 0) >= idle_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            t_answer got, want;
            got = {o_status, o_alloc_offset, o_free_total, o_released_count};
            if (answers_due.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result beat %h", got);
            end else begin
                want = answers_due[0];
                answers_due.delete(0);
                if (got !== want) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: status %0d/%0d grant %h/%h free %h/%h rel %0d/%0d",
                                 want.status, got.status, want.grant, got.grant,
                                 want.free_total, got.free_total, want.released, got.released);
                end
            end
        end
    end

    // watchdog on cycles with no beat accepted
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || hold_off)
            quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG) begin
            $display("FAIL best_fit_range_allocator");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(3, 0))
            0: return $urandom_range(64, 0);
            1: return $urandom_range(4096, 0);
            2: return 32'hFFFF_FFFF - $urandom_range(3, 0);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_action(bfra_pkg::ACT_ALLOC, '0, 32'd0, '0);
        send_action(bfra_pkg::ACT_ALLOC, '0, 32'd100, '0);
        send_action(bfra_pkg::ACT_ALLOC, '0, 32'd200, '0);
        send_action(bfra_pkg::ACT_ALLOC, '0, 32'hFFFF_FFFF, '0);
        send_action(bfra_pkg::ACT_FREE, 32'd0, 32'd0, '0);
        send_action(bfra_pkg::ACT_FREE, 32'd0, 32'd100, '0);
        send_action(bfra_pkg::ACT_FREE, 32'd100, 32'd200, '0);
        send_action(bfra_pkg::ACT_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
        send_action(bfra_pkg::ACT_ALLOC, '0, 32'd1, '0);
        send_action(bfra_pkg::ACT_DEFER, 32'd0, 32'd1, 64'd5);
        send_action(bfra_pkg::ACT_DEFER, 32'd50, 32'd7, 64'hFFFF_FFFF_FFFF_FFFF);
        send_action(bfra_pkg::ACT_RELEASE, '0, '0, 64'd4);
        send_action(bfra_pkg::ACT_RELEASE, '0, '0, 64'd5);
        send_action(bfra_pkg::ACT_RELEASE, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF);
    endtask

    // fill the table with fragments until free reports table full
    task automatic test_table_full();
        write_total(32'd100000);
        for (int i = 0; i < 66; i++) send_action(bfra_pkg::ACT_ALLOC, '0, 32'd10, '0);
        for (int i = 0; i < 66; i++) send_action(bfra_pkg::ACT_FREE, 32'(i * 20), 32'd10, '0);
        for (int i = 0; i < 4; i++)
            send_action(bfra_pkg::ACT_DEFER, 32'(i * 20 + 5000), 32'd3, 64'(i));
        send_action(bfra_pkg::ACT_RELEASE, '0, '0, 64'd10);
    endtask

    // overflow the deferred queue, with a receiver hold-off stalling its first result
    task automatic test_queue_full_and_stall();
        write_total(32'd1048576);
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(negedge i_clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 20; i++)
                send_action(bfra_pkg::ACT_DEFER, $urandom_range(2000, 0), 32'd4, 64'(i));
        join
        send_action(bfra_pkg::ACT_RELEASE, '0, '0, 64'd100);
    endtask

    task automatic test_random(int n_items, logic [31:0] total);
        logic [31:0] o, s;
        write_total(total);
        for (int i = 0; i < n_items; i++) begin
            idle_pct = (i % 300 < 60) ? 0 : 35;
            o = rand_word();
            s = ($urandom_range(9, 0) < 8) ? $urandom_range(300, 0) : rand_word();
            case ($urandom_range(9, 0))
                0, 1, 2, 3: send_action(bfra_pkg::ACT_ALLOC, $urandom, s, {$urandom, $urandom});
                4, 5: send_action(bfra_pkg::ACT_FREE, ($urandom_range(1, 0) ? o : o % total), s,
                                  {$urandom, $urandom});
                6, 7: send_action(bfra_pkg::ACT_DEFER, 32'(o % (total + 64'd1)), s,
                                  $urandom_range(1, 0) ? 64'(i) : {$urandom, $urandom});
                default: send_action(bfra_pkg::ACT_RELEASE, $urandom, $urandom,
                                     $urandom_range(3, 0) ? 64'(i) : {$urandom, $urandom});
            endcase
        end
        idle_pct = 35;
    endtask

    initial begin
        table_load(64'd1048576);
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_table_full();
        test_queue_full_and_stall();
        write_total(32'd0);
        send_action(bfra_pkg::ACT_ALLOC, '0, 32'd1, '0);
        send_action(bfra_pkg::ACT_FREE, 32'd0, 32'd8, '0);
        test_random(400, 32'd1048576);
        test_random(300, 32'd5000);
        test_random(300, 32'hFFFF_FFFF);
        test_random(180, 32'd1);
        drain_wait();
        if (n_errors == 0) $display("PASS best_fit_range_allocator");
        else $display("FAIL best_fit_range_allocator");
        $finish;
    end

endmodule
